### design/assert_macros.svh
// Assertion macros shared by the line filter RTL.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### design/sglf_pkg.sv
// Package of the symmetric line filter: sizes, register and border codes,
// shared types and the window tap selection function. No dependencies.
`default_nettype none
package sglf_pkg;
	localparam int MAX_HALF = 7;
	localparam int WIN_DEPTH = 2 * MAX_HALF + 1;
	localparam int NUM_TAPS = MAX_HALF + 1;
	localparam int SAMPLE_W = 16;
	localparam int POS_W = 13;
	localparam logic [POS_W-1:0] POS_SAT = 13'd8191;
	localparam int PRESUM_W = SAMPLE_W + 1;
	localparam int PROD_W = PRESUM_W + SAMPLE_W;
	localparam int ACC_W = PROD_W + 3;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	localparam logic [1:0] REG_COEF_LOW = 2'd0;
	localparam logic [1:0] REG_COEF_HIGH = 2'd1;
	localparam logic [1:0] REG_HALF_WIDTH = 2'd2;
	localparam logic [1:0] REG_BORDER_MODE = 2'd3;

	localparam logic [1:0] BORDER_ZERO = 2'd0;
	localparam logic [1:0] BORDER_MIRROR = 2'd1;
	localparam logic [1:0] BORDER_COPY = 2'd2;

	typedef logic [WIN_DEPTH-1:0][SAMPLE_W-1:0] window_t;

	typedef struct packed {
		window_t win;
		logic [POS_W-1:0] pos;
		logic eol;
	} job_t;

	typedef struct packed {
		logic [NUM_TAPS-1:0][SAMPLE_W-1:0] coef;
		logic [2:0] half;
		logic mirror;
		logic copy;
	} cfg_t;

	typedef struct packed {
		logic hit;
		logic [3:0] idx;
	} tap_sel_t;

	// Maps a tap offset around the center to a window slot, applying the
	// border rule. The center sits c slots behind the newest sample, kc is
	// the center's line position limited to eight.
	function automatic tap_sel_t tap_select(input logic signed [4:0] t,
			input logic [2:0] c, input logic [3:0] kc, input logic mirror);
		logic signed [6:0] tt;
		logic signed [6:0] kk;
		logic signed [6:0] rr;
		logic signed [6:0] dd;
		tap_sel_t sel;
		tt = 7'(t);
		kk = $signed({3'b000, kc});
		rr = $signed({4'b0000, c});
		sel.hit = 1'b1;
		sel.idx = '0;
		if (tt < -kk || tt > rr) begin
			if (!mirror) begin
				sel.hit = 1'b0;
			end else if (tt < -kk) begin
				tt = -7'sd1 - kk - kk - tt;
				if (tt > rr) begin
					tt = rr;
				end
			end else begin
				tt = rr + rr + 7'sd1 - tt;
				if (tt < -kk) begin
					tt = -kk;
				end
			end
		end
		dd = rr - tt;
		if (dd < 7'sd0 || dd > 7'(WIN_DEPTH - 1)) begin
			sel.hit = 1'b0;
		end else begin
			sel.idx = dd[3:0];
		end
		return sel;
	endfunction
endpackage
`default_nettype wire

### design/sglf_front.sv
// Front end of the line filter: accepts samples, keeps the sample window and
// line position, and queues a job for every sample that releases results.
// Depends on sglf_pkg.
`default_nettype none
module sglf_front import sglf_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic [SAMPLE_W-1:0] sample,
	input  wire logic end_of_line,
	input  wire cfg_t cfg,
	input  wire logic q_full,
	output logic q_push,
	output job_t q_job
);
	window_t win_q;
	logic [POS_W-1:0] pos_q;
	logic accept;
	window_t win_next;

	assign in_stall = q_full;
	assign accept = in_valid && !in_stall;
	assign win_next = {win_q[WIN_DEPTH-2:0], sample};

	assign q_push = accept && (end_of_line || pos_q >= {{(POS_W-3){1'b0}}, cfg.half});
	assign q_job.win = win_next;
	assign q_job.pos = pos_q;
	assign q_job.eol = end_of_line;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			pos_q <= '0;
		end else if (accept) begin
			win_q <= win_next;
			if (end_of_line) begin
				pos_q <= '0;
			end else if (pos_q != POS_SAT) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

### design/sglf_fifo.sv
// Short job queue between the front and back ends of the line filter.
// Depends on sglf_pkg.
`default_nettype none
module sglf_fifo import sglf_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	input  wire logic pop,
	output job_t head_job,
	output logic full,
	output logic empty
);
	job_t mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full = (count_q == QCNT_W'(QDEPTH));
	assign empty = (count_q == '0);
	assign head_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

### design/sglf_back.sv
// Back end of the line filter: expands each job into its output positions,
// gathers taps, multiplies, sums, rounds and saturates in a stalling pipeline.
// Depends on sglf_pkg.
`default_nettype none
module sglf_back import sglf_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire job_t head_job,
	input  wire logic q_empty,
	output logic q_pop,
	output logic out_valid,
	input  wire logic out_stall,
	output logic [SAMPLE_W-1:0] filtered_value,
	output logic line_done,
	output logic last_in_run
);
	typedef struct packed {
		logic done;
		logic last;
		logic byp;
		logic [SAMPLE_W-1:0] byp_val;
	} tag_t;

	logic adv;
	logic cur_valid_q;
	job_t cur_q;
	logic [2:0] cnt_q;
	logic cur_done;
	logic [2:0] cnt_init;
	logic [POS_W-1:0] k;
	logic [3:0] kc;
	tap_sel_t tsel;
	logic signed [SAMPLE_W-1:0] tap_val [WIN_DEPTH];
	logic signed [PRESUM_W-1:0] presum [NUM_TAPS];
	tag_t tag_in;

	logic v_s1, v_s2, v_s3, v_s4;
	tag_t tag_s1, tag_s2, tag_s3, tag_s4;
	logic signed [PRESUM_W-1:0] presum_s1 [NUM_TAPS];
	logic signed [PROD_W-1:0] prod_s2 [NUM_TAPS];
	logic signed [ACC_W-1:0] sum_s3 [NUM_TAPS/2];
	logic signed [ACC_W-1:0] sum_s4 [NUM_TAPS/4];
	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W-1:0] rnd;
	logic [SAMPLE_W-1:0] sat_val;

	logic out_valid_q;
	logic [SAMPLE_W-1:0] value_q;
	logic line_done_q;
	logic last_q;

	assign adv = !(out_valid_q && out_stall);
	assign cur_done = !cur_q.eol || (cnt_q == '0);
	assign q_pop = adv && !q_empty && (!cur_valid_q || cur_done);
	assign cnt_init = (head_job.eol && head_job.pos < {{(POS_W-3){1'b0}}, cfg.half})
		? head_job.pos[2:0] : cfg.half;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
		end else if (adv) begin
			if (q_pop) begin
				cur_valid_q <= 1'b1;
			end else if (cur_done) begin
				cur_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (q_pop) begin
				cur_q <= head_job;
				cnt_q <= cnt_init;
			end else if (cur_valid_q && !cur_done) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign k = cur_q.pos - {{(POS_W-3){1'b0}}, cnt_q};
	assign kc = (k >= POS_W'(8)) ? 4'd8 : k[3:0];

	always_comb begin
		tsel = '0;
		for (int j = 0; j < WIN_DEPTH; j++) begin
			tsel = tap_select(5'(j - MAX_HALF), cnt_q, kc, cfg.mirror);
			tap_val[j] = tsel.hit ? $signed(cur_q.win[tsel.idx]) : '0;
		end
		presum[0] = PRESUM_W'(tap_val[MAX_HALF]);
		for (int i = 1; i < NUM_TAPS; i++) begin
			presum[i] = (i <= int'(cfg.half))
				? PRESUM_W'(tap_val[MAX_HALF-i]) + PRESUM_W'(tap_val[MAX_HALF+i]) : '0;
		end
	end

	always_comb begin
		tag_in.done = cur_q.eol && (cnt_q == '0);
		tag_in.last = cur_done;
		tag_in.byp = cfg.copy && ((k < {{(POS_W-3){1'b0}}, cfg.half}) || (cnt_q < cfg.half));
		tag_in.byp_val = cur_q.win[{1'b0, cnt_q}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= cur_valid_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			for (int i = 0; i < NUM_TAPS; i++) begin
				presum_s1[i] <= presum[i];
				prod_s2[i] <= PROD_W'(presum_s1[i]) * PROD_W'($signed(cfg.coef[i]));
			end
			for (int j = 0; j < NUM_TAPS / 2; j++) begin
				sum_s3[j] <= ACC_W'(prod_s2[2*j]) + ACC_W'(prod_s2[2*j+1]);
			end
			for (int j = 0; j < NUM_TAPS / 4; j++) begin
				sum_s4[j] <= sum_s3[2*j] + sum_s3[2*j+1];
			end
			value_q <= tag_s4.byp ? tag_s4.byp_val : sat_val;
			line_done_q <= tag_s4.done;
			last_q <= tag_s4.last;
		end
	end

	always_comb begin
		acc = sum_s4[0] + sum_s4[1] + ACC_W'(1 << 14);
		rnd = acc >>> 15;
		if (rnd > ACC_W'(32767)) begin
			sat_val = 16'h7fff;
		end else if (rnd < -ACC_W'(32768)) begin
			sat_val = 16'h8000;
		end else begin
			sat_val = rnd[SAMPLE_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign filtered_value = value_q;
	assign line_done = line_done_q;
	assign last_in_run = last_q;
endmodule
`default_nettype wire

### design/symmetric_gaussian_line_filter.sv
// Top level of the symmetric line filter: configuration registers, front end,
// job queue and back end. Depends on sglf_pkg, sglf_front, sglf_fifo,
// sglf_back and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Samples of a line enter one per cycle while the job queue has room; a
// sample produces its filtered output half_width positions later, and the
// end-of-line sample releases the remaining min(position, half_width) + 1
// outputs, one per cycle from the back-end issue counter while the output
// is not stalled. The flush overlaps the first half_width samples of the
// next line, which release nothing, so lines stream at one sample per
// cycle when both sides keep up. A four-entry job queue lets the input side
// keep accepting while the flush runs. The back end is a five-stage pipeline
// (tap gather, multiply, two adder levels, round and saturate) that holds
// while the output is stalled. No clearing pass is needed after reset.
module symmetric_gaussian_line_filter import sglf_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic [SAMPLE_W-1:0] sample,
	input  wire logic end_of_line,
	output logic out_valid,
	input  wire logic out_stall,
	output logic [SAMPLE_W-1:0] filtered_value,
	output logic line_done,
	output logic last_in_run,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [63:0] cfg_data
);
	logic [63:0] coef_low_q;
	logic [63:0] coef_high_q;
	logic [2:0] half_width_q;
	logic [1:0] border_mode_q;
	cfg_t cfg;
	logic q_push;
	job_t q_job;
	logic q_full;
	logic q_empty;
	logic q_pop;
	job_t head_job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_low_q <= 64'd32767;
			coef_high_q <= '0;
			half_width_q <= '0;
			border_mode_q <= BORDER_ZERO;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_COEF_LOW: coef_low_q <= cfg_data;
				REG_COEF_HIGH: coef_high_q <= cfg_data;
				REG_HALF_WIDTH: half_width_q <= cfg_data[2:0];
				REG_BORDER_MODE: border_mode_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign cfg.coef = {coef_high_q, coef_low_q};
	assign cfg.half = half_width_q;
	assign cfg.mirror = (border_mode_q == BORDER_MIRROR);
	assign cfg.copy = (border_mode_q == BORDER_COPY);

	sglf_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.end_of_line(end_of_line),
		.cfg(cfg),
		.q_full(q_full),
		.q_push(q_push),
		.q_job(q_job)
	);

	sglf_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_job(q_job),
		.pop(q_pop),
		.head_job(head_job),
		.full(q_full),
		.empty(q_empty)
	);

	sglf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.head_job(head_job),
		.q_empty(q_empty),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.filtered_value(filtered_value),
		.line_done(line_done),
		.last_in_run(last_in_run)
	);

	`ASSERT_IMPLIES(a_no_overflow, q_push, !q_full)
	`ASSERT_IMPLIES(a_no_underflow, q_pop, !q_empty)
	`ASSERT_IMPLIES(a_done_is_last, out_valid && line_done, last_in_run)
	`ASSERT_NEXT(a_half_write, cfg_valid && cfg_index == REG_HALF_WIDTH, cfg.half == $past(cfg_data[2:0]))
endmodule
`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for symmetric_gaussian_line_filter: random lines under all border rules.
// A scoreboard class predicts every filtered word; tasks drive sample and register words.
// Depends on sglf_pkg and the filter RTL only.
module tb;
	import sglf_pkg::*;

	typedef struct {
		logic [SAMPLE_W-1:0] value;
		logic line_end;
		logic run_end;
	} blur_word_t;

	class line_blur_checker;
		logic signed [SAMPLE_W-1:0] tap_coef [NUM_TAPS];
		logic [2:0] taps_per_side;
		logic [1:0] border_rule;
		logic signed [SAMPLE_W-1:0] recent [WIN_DEPTH];
		logic [POS_W-1:0] line_pos;
		blur_word_t expected_filtered [$];
		int unsigned failures;

		function new();
			foreach (tap_coef[i]) tap_coef[i] = '0;
			foreach (recent[i]) recent[i] = '0;
			tap_coef[0] = 16'sh7FFF;
			taps_per_side = '0;
			border_rule = BORDER_ZERO;
			line_pos = '0;
			failures = 0;
		endfunction

		function void write_reg(logic [1:0] index, logic [63:0] data);
			case (index)
				REG_COEF_LOW: begin
					for (int i = 0; i < 4; i++) tap_coef[i] = data[16*i +: 16];
				end
				REG_COEF_HIGH: begin
					for (int i = 0; i < 4; i++) tap_coef[i + 4] = data[16*i +: 16];
				end
				REG_HALF_WIDTH: taps_per_side = data[2:0];
				REG_BORDER_MODE: border_rule = data[1:0];
				default: ;
			endcase
		endfunction

		// Sample at offset t from a center that sits c words behind the newest
		// one; k is the center's line position and c positions follow it.
		function longint window_tap(int t, int c, int k, bit mirror);
			int d;
			if (t < -k || t > c) begin
				if (!mirror) return 0;
				if (t < -k) begin
					t = -1 - 2 * k - t;
					if (t > c) t = c;
				end else begin
					t = 2 * c + 1 - t;
					if (t < -k) t = -k;
				end
			end
			d = c - t;
			if (d < 0 || d >= WIN_DEPTH) return 0;
			return longint'(recent[d]);
		endfunction

		function logic [SAMPLE_W-1:0] blur_at(int c, int k, int h, logic [1:0] rule);
			longint acc;
			bit mirror;
			mirror = (rule == BORDER_MIRROR);
			if (rule == BORDER_COPY && (k < h || c < h)) return recent[c];
			acc = longint'(tap_coef[0]) * window_tap(0, c, k, mirror);
			for (int i = 1; i <= h; i++) begin
				acc += longint'(tap_coef[i]) *
					(window_tap(-i, c, k, mirror) + window_tap(i, c, k, mirror));
			end
			acc = (acc + 64'sd16384) >>> 15;
			if (acc > 32767) acc = 32767;
			else if (acc < -32768) acc = -32768;
			return acc[15:0];
		endfunction

		function void note_sample(logic [SAMPLE_W-1:0] s, logic eol);
			int h;
			int p;
			int top;
			logic tail;
			h = taps_per_side;
			p = line_pos;
			for (int d = WIN_DEPTH - 1; d > 0; d--) recent[d] = recent[d - 1];
			recent[0] = s;
			if (eol) begin
				top = (p < h) ? p : h;
				for (int c = top; c >= 0; c--) begin
					tail = (c == 0);
					expected_filtered.push_back('{blur_at(c, p - c, h, border_rule), tail, tail});
				end
				line_pos = '0;
			end else begin
				if (p >= h) begin
					expected_filtered.push_back('{blur_at(h, p - h, h, border_rule), 1'b0, 1'b1});
				end
				if (line_pos < POS_SAT) line_pos++;
			end
		endfunction

		function void check_output(logic [SAMPLE_W-1:0] v, logic done, logic last);
			blur_word_t want;
			if (expected_filtered.size() == 0) begin
				failures++;
				$error("unexpected word: filtered_value %0d", $signed(v));
				return;
			end
			want = expected_filtered.pop_front();
			if (v !== want.value) begin
				failures++;
				$error("filtered_value: expected %0d, got %0d", $signed(want.value), $signed(v));
			end
			if (done !== want.line_end) begin
				failures++;
				$error("line_done: expected %0b, got %0b", want.line_end, done);
			end
			if (last !== want.run_end) begin
				failures++;
				$error("last_in_run: expected %0b, got %0b", want.run_end, last);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [SAMPLE_W-1:0] sample;
	logic end_of_line;
	logic out_valid;
	logic out_stall;
	logic [SAMPLE_W-1:0] filtered_value;
	logic line_done;
	logic last_in_run;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [63:0] cfg_data;

	int send_idle_pct;
	int recv_stall_pct;
	int quiet_cycles = 0;
	line_blur_checker blur_sb;

	symmetric_gaussian_line_filter dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.end_of_line(end_of_line),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.filtered_value(filtered_value),
		.line_done(line_done),
		.last_in_run(last_in_run),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				blur_sb.check_output(filtered_value, line_done, last_in_run);
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= 4000) begin
			$display("symmetric_gaussian_line_filter regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [SAMPLE_W-1:0] any_sample();
		case ($urandom_range(15))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_word(logic [SAMPLE_W-1:0] s, logic eol);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		end_of_line <= eol;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		blur_sb.note_sample(s, eol);
	endtask

	task automatic send_line(int len);
		for (int i = 0; i < len; i++) send_word(any_sample(), i == len - 1);
	endtask

	// Registers change only once every pending word has come out and the
	// pipeline has had time to retire words that produce no output.
	task automatic settle();
		in_valid <= 1'b0;
		while (blur_sb.expected_filtered.size() != 0) @(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	task automatic configure(logic [63:0] lo, logic [63:0] hi, logic [2:0] hw, logic [1:0] rule);
		logic [63:0] words [4];
		logic [63:0] noise;
		noise = {$urandom, $urandom};
		words[REG_COEF_LOW] = lo;
		words[REG_COEF_HIGH] = hi;
		words[REG_HALF_WIDTH] = {noise[63:3], hw};
		words[REG_BORDER_MODE] = {noise[63:2], rule};
		cfg_valid <= 1'b1;
		for (int i = 0; i < 4; i++) begin
			cfg_index <= 2'(i);
			cfg_data <= words[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			blur_sb.write_reg(2'(i), words[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic random_setup();
		logic [63:0] lo;
		logic [63:0] hi;
		logic [2:0] hw;
		logic [1:0] rule;
		int spread;
		hw = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 3'd7 : 3'd0) : 3'($urandom_range(7));
		rule = 2'($urandom_range(3));
		case ($urandom_range(3))
			0: begin
				lo = {$urandom, $urandom};
				hi = {$urandom, $urandom};
			end
			1: begin
				for (int i = 0; i < 4; i++) begin
					lo[16*i +: 16] = $urandom_range(1) ? 16'h7FFF : 16'h8000;
					hi[16*i +: 16] = $urandom_range(1) ? 16'h7FFF : 16'h8000;
				end
			end
			default: begin
				spread = 32768 / (2 * hw + 1);
				for (int i = 0; i < 4; i++) begin
					lo[16*i +: 16] = 16'($urandom_range(spread));
					hi[16*i +: 16] = 16'($urandom_range(spread));
				end
				lo[15:0] = 16'($urandom_range(spread, 2 * spread));
			end
		endcase
		configure(lo, hi, hw, rule);
	endtask

	task automatic random_lines(int items);
		int sent;
		int len;
		sent = 0;
		while (sent < items) begin
			settle();
			random_setup();
			repeat ($urandom_range(1, 4)) begin
				if ($urandom_range(3) == 0) len = $urandom_range(16, 40);
				else len = $urandom_range(1, 2 * blur_sb.taps_per_side + 3);
				send_line(len);
				sent += len;
			end
		end
	endtask

	initial begin
		blur_sb = new();
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		sample <= '0;
		end_of_line <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_COEF_LOW;
		cfg_data <= '0;
		send_idle_pct = 13;
		recv_stall_pct = 78;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(16'h7FFF, 1'b0);
		send_word(16'h8000, 1'b0);
		send_word(16'h0000, 1'b0);
		send_word(16'hFFFF, 1'b1);
		send_word(16'h1234, 1'b1);
		settle();
		configure({4{16'h7FFF}}, {4{16'h7FFF}}, 3'd7, BORDER_MIRROR);
		send_word(16'h7FFF, 1'b0);
		send_word(16'h7FFF, 1'b0);
		send_word(16'h8000, 1'b1);
		settle();
		configure({4{16'h8000}}, {4{16'h8000}}, 3'd7, BORDER_COPY);
		send_line(16);

		random_lines(55);
		settle();
		send_idle_pct = 78;
		recv_stall_pct = 13;
		random_lines(55);
		settle();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_lines(45);
		settle();

		if (blur_sb.failures == 0) begin
			$display("symmetric_gaussian_line_filter regression: pass");
		end else begin
			$display("symmetric_gaussian_line_filter regression: fail");
		end
		$finish;
	end
endmodule
